// ----- rtl/symbolic_tag_path_encoder_defines.svh -----
// Assertion macros shared by the symbolic tag path encoder RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef SYMBOLIC_TAG_PATH_ENCODER_DEFINES_SVH
`define SYMBOLIC_TAG_PATH_ENCODER_DEFINES_SVH
// Same-cycle implication, disabled while reset is high.
`define STPE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, disabled while reset is high.
`define STPE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ----- rtl/stpe_pkg.sv -----
// Shared types, codes and helpers for the symbolic tag path encoder.
// Used by the controller, the datapath and the top level; depends on nothing.
package stpe_pkg;

   localparam int RSP_DATA_W = 24;

   localparam logic [7:0] CHAR_NUL  = 8'h00;
   localparam logic [7:0] CHAR_DOT  = 8'h2E;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [7:0] CHAR_LBR  = 8'h5B;
   localparam logic [7:0] CHAR_RBR  = 8'h5D;

   localparam logic [7:0] SEG_SYMBOL = 8'h91;
   localparam logic [7:0] SEG_IDX8   = 8'h28;
   localparam logic [7:0] SEG_IDX16  = 8'h29;
   localparam logic [7:0] SEG_IDX32  = 8'h2A;
   localparam logic [7:0] PAD_BYTE   = 8'h00;

   localparam logic [3:0] MAX_DIGITS = 4'd10;

   localparam logic [2:0] IDX_LEN8  = 3'd2;
   localparam logic [2:0] IDX_LEN16 = 3'd4;
   localparam logic [2:0] IDX_LEN32 = 3'd6;

   typedef enum logic [1:0] {
      MODE_NAME,
      MODE_INDEX,
      MODE_AFTER
   } mode_type;

   typedef enum logic [2:0] {
      ERR_NONE,
      ERR_SYMLEN,
      ERR_INDEX,
      ERR_CHAR,
      ERR_LONG,
      ERR_EMPTY
   } err_type;

   typedef enum logic [2:0] {
      SEL_HDR,
      SEL_LEN,
      SEL_BODY,
      SEL_PAD,
      SEL_IDX
   } sel_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_NAME_HDR,
      S_NAME_LEN,
      S_NAME_BODY,
      S_NAME_PAD,
      S_INDEX,
      S_CLOSE
   } state_type;

   typedef struct packed {
      logic     take;
      logic     store_char;
      logic     acc_digit;
      logic     idx_clear;
      logic     mode_wr;
      mode_type mode_val;
      logic     err_wr;
      err_type  err_val;
      logic     name_start;
      logic     name_clear;
      logic     emit;
      sel_type  sel;
      logic     emit_close;
      logic     clear_all;
      logic     rd_adv;
      logic     idx_start;
      logic     idx_adv;
   } cmd_type;

   typedef struct packed {
      logic     is_nul;
      logic     is_lbr;
      logic     is_rbr;
      logic     is_dot;
      logic     is_digit;
      mode_type mode;
      logic     err_set;
      logic     name_empty;
      logic     name_full;
      logic     emitted_zero;
      logic     name_fits;
      logic     index_fits;
      logic     digit_ovf;
      logic     digits_zero;
      logic     out_free;
      logic     name_last;
      logic     name_odd;
      logic     idx_last;
   } status_type;

   // Number of bytes in the index segment for a given index value.
   function automatic logic [2:0] index_len(input logic [31:0] v);
      logic [2:0] len;
      if (v[31:8] == 24'd0) begin
         len = IDX_LEN8;
      end else if (v[31:16] == 16'd0) begin
         len = IDX_LEN16;
      end else begin
         len = IDX_LEN32;
      end
      return len;
   endfunction

   // Byte k of the index segment, segment code first, value little endian.
   function automatic logic [7:0] index_byte(input logic [31:0] v, input logic [2:0] k);
      logic [7:0] b;
      logic       short_form;
      short_form = (v[31:8] == 24'd0);
      case (k)
         3'd0: begin
            if (short_form) begin
               b = SEG_IDX8;
            end else if (v[31:16] == 16'd0) begin
               b = SEG_IDX16;
            end else begin
               b = SEG_IDX32;
            end
         end
         3'd1: b = short_form ? v[7:0] : PAD_BYTE;
         3'd2: b = v[7:0];
         3'd3: b = v[15:8];
         3'd4: b = v[23:16];
         3'd5: b = v[31:24];
         default: b = PAD_BYTE;
      endcase
      return b;
   endfunction

endpackage

// ----- rtl/stpe_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; holds the buffered tag name characters.
module stpe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 40
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/stpe_dp.sv -----
// Datapath of the symbolic tag path encoder: parse state, name buffer,
// index accumulator, byte counter and output register. Uses stpe_pkg, stpe_ram.
module stpe_dp #(
   parameter int MAX_NAME_LEN   = 40,
   parameter int MAX_PATH_BYTES = 512
) (
   input  logic                                clock,
   input  logic                                reset,
   input  stpe_pkg::cmd_type                   cmd,
   output stpe_pkg::status_type                status,
   input  logic                                req_tvalid,
   input  logic [7:0]                          req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [stpe_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tuser,
   output logic                                rsp_tlast
);
   import stpe_pkg::*;

   localparam int CW = $clog2(MAX_NAME_LEN + 1);
   localparam int AW = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1;
   localparam int BW = $clog2(MAX_PATH_BYTES + 1);
   localparam int SW = ((BW > 9) ? BW : 9) + 1;

   logic [7:0]    char_ff, char_in;
   mode_type      mode_ff, mode_in;
   logic [CW-1:0] name_count_ff, name_count_in;
   logic [31:0]   acc_ff, acc_in;
   logic [3:0]    digit_ff, digit_in;
   logic [BW-1:0] emitted_ff, emitted_in;
   err_type       err_ff, err_in;
   logic [CW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0]    idx_k_ff, idx_k_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;
   logic          rsp_user_ff, rsp_user_in;
   logic          rsp_last_ff, rsp_last_in;
   err_type       rsp_err_ff, rsp_err_in;
   logic [9:0]    rsp_len_ff, rsp_len_in;

   logic [7:0]     ram_rd;
   logic [35:0]    acc_wide;
   logic [2:0]     idx_len;
   logic [SW-1:0]  name_need, idx_need;
   logic [BW+9:0]  emitted_ext;
   err_type        close_err;
   logic [7:0]     sel_byte;
   logic           out_free;

   stpe_ram #(
      .WIDTH (8),
      .DEPTH (MAX_NAME_LEN)
   ) u_name_ram (
      .clock   (clock),
      .wr_en   (cmd.store_char),
      .wr_addr (name_count_ff[AW-1:0]),
      .wr_data (char_ff),
      .rd_addr (rd_ptr_in[AW-1:0]),
      .rd_data (ram_rd)
   );

   // Times ten plus the digit, wide enough to see an overflow past 32 bits.
   assign acc_wide = 36'({acc_ff, 3'b000}) + 36'({acc_ff, 1'b0}) + 36'(char_ff[3:0]);
   assign idx_len  = index_len(acc_ff);
   assign name_need = SW'(emitted_ff) + SW'(name_count_ff) + SW'(2) + SW'(name_count_ff[0]);
   assign idx_need  = SW'(emitted_ff) + SW'(idx_len);
   assign emitted_ext = (BW + 10)'(emitted_ff);
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      if (err_ff == ERR_NONE && emitted_ff == '0) begin
         close_err = ERR_EMPTY;
      end else begin
         close_err = err_ff;
      end
   end

   always_comb begin
      case (cmd.sel)
         SEL_HDR:  sel_byte = SEG_SYMBOL;
         SEL_LEN:  sel_byte = 8'(name_count_ff);
         SEL_BODY: sel_byte = ram_rd;
         SEL_IDX:  sel_byte = index_byte(acc_ff, idx_k_ff);
         default:  sel_byte = PAD_BYTE;
      endcase
   end

   always_comb begin
      status.is_nul       = (char_ff == CHAR_NUL);
      status.is_lbr       = (char_ff == CHAR_LBR);
      status.is_rbr       = (char_ff == CHAR_RBR);
      status.is_dot       = (char_ff == CHAR_DOT);
      status.is_digit     = (char_ff >= CHAR_ZERO) && (char_ff <= CHAR_NINE);
      status.mode         = mode_ff;
      status.err_set      = (err_ff != ERR_NONE);
      status.name_empty   = (name_count_ff == '0);
      status.name_full    = (name_count_ff >= CW'(MAX_NAME_LEN));
      status.emitted_zero = (emitted_ff == '0);
      status.name_fits    = (name_need <= SW'(MAX_PATH_BYTES));
      status.index_fits   = (idx_need <= SW'(MAX_PATH_BYTES));
      status.digit_ovf    = (digit_ff >= MAX_DIGITS) || (acc_wide[35:32] != 4'd0);
      status.digits_zero  = (digit_ff == 4'd0);
      status.out_free     = out_free;
      status.name_last    = ((rd_ptr_ff + CW'(1)) == name_count_ff);
      status.name_odd     = name_count_ff[0];
      status.idx_last     = (idx_k_ff == (idx_len - 3'd1));
   end

   always_comb begin
      char_in       = char_ff;
      mode_in       = mode_ff;
      name_count_in = name_count_ff;
      acc_in        = acc_ff;
      digit_in      = digit_ff;
      emitted_in    = emitted_ff;
      err_in        = err_ff;
      rd_ptr_in     = rd_ptr_ff;
      idx_k_in      = idx_k_ff;

      if (cmd.take && req_tvalid) begin
         char_in = req_tdata;
      end
      if (cmd.name_start) begin
         rd_ptr_in = '0;
      end else if (cmd.rd_adv) begin
         rd_ptr_in = rd_ptr_ff + CW'(1);
      end
      if (cmd.idx_start) begin
         idx_k_in = 3'd0;
      end else if (cmd.idx_adv) begin
         idx_k_in = idx_k_ff + 3'd1;
      end

      if (cmd.clear_all) begin
         mode_in       = MODE_NAME;
         name_count_in = '0;
         acc_in        = '0;
         digit_in      = 4'd0;
         emitted_in    = '0;
         err_in        = ERR_NONE;
      end else begin
         if (cmd.store_char) begin
            name_count_in = name_count_ff + CW'(1);
         end
         if (cmd.name_clear) begin
            name_count_in = '0;
         end
         if (cmd.acc_digit) begin
            acc_in   = acc_wide[31:0];
            digit_in = digit_ff + 4'd1;
         end
         if (cmd.idx_clear) begin
            mode_in  = MODE_INDEX;
            acc_in   = '0;
            digit_in = 4'd0;
         end
         if (cmd.mode_wr) begin
            mode_in = cmd.mode_val;
         end
         if (cmd.err_wr) begin
            err_in = cmd.err_val;
         end
         if (cmd.emit) begin
            emitted_in = emitted_ff + BW'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_len_in   = rsp_len_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = sel_byte;
         rsp_user_in  = 1'b1;
         rsp_last_in  = 1'b0;
         rsp_err_in   = ERR_NONE;
         rsp_len_in   = 10'd0;
      end else if (cmd.emit_close) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = PAD_BYTE;
         rsp_user_in  = 1'b0;
         rsp_last_in  = 1'b1;
         rsp_err_in   = close_err;
         rsp_len_in   = (close_err == ERR_NONE) ? emitted_ext[9:0] : 10'd0;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_NAME;
         name_count_ff <= '0;
         acc_ff        <= '0;
         digit_ff      <= 4'd0;
         emitted_ff    <= '0;
         err_ff        <= ERR_NONE;
         rd_ptr_ff     <= '0;
         idx_k_ff      <= 3'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         name_count_ff <= name_count_in;
         acc_ff        <= acc_in;
         digit_ff      <= digit_in;
         emitted_ff    <= emitted_in;
         err_ff        <= err_in;
         rd_ptr_ff     <= rd_ptr_in;
         idx_k_ff      <= idx_k_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff     <= char_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
      rsp_err_ff  <= rsp_err_in;
      rsp_len_ff  <= rsp_len_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_len_ff, rsp_err_ff, rsp_byte_ff};
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- rtl/stpe_ctrl.sv -----
// Controller state machine of the symbolic tag path encoder.
// Decodes each character from datapath status and sequences segment output. Uses stpe_pkg.
module stpe_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  stpe_pkg::status_type status,
   output stpe_pkg::cmd_type    cmd
);
   import stpe_pkg::*;

   state_type state_ff, state_in;
   logic      close_after_ff, close_after_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         close_after_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         close_after_ff <= close_after_in;
      end
   end

   always_comb begin
      cmd            = '0;
      cmd.mode_val   = MODE_NAME;
      cmd.err_val    = ERR_NONE;
      cmd.sel        = SEL_PAD;
      state_in       = state_ff;
      close_after_in = close_after_ff;

      case (state_ff)
         S_IDLE: begin
            cmd.take = 1'b1;
            if (req_tvalid) begin
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            state_in = S_IDLE;
            if (status.err_set) begin
               // A latched error swallows everything up to the terminator.
               if (status.is_nul) begin
                  state_in = S_CLOSE;
               end
            end else begin
               case (status.mode)
                  MODE_NAME: begin
                     if (status.is_nul && status.emitted_zero && status.name_empty) begin
                        state_in = S_CLOSE;
                     end else if (status.is_nul || status.is_lbr || status.is_dot) begin
                        if (status.name_empty) begin
                           cmd.err_wr  = 1'b1;
                           cmd.err_val = ERR_SYMLEN;
                           if (status.is_nul) begin
                              state_in = S_CLOSE;
                           end
                        end else if (!status.name_fits) begin
                           cmd.err_wr  = 1'b1;
                           cmd.err_val = ERR_LONG;
                           if (status.is_nul) begin
                              state_in = S_CLOSE;
                           end
                        end else begin
                           cmd.name_start = 1'b1;
                           cmd.idx_clear  = status.is_lbr;
                           close_after_in = status.is_nul;
                           state_in       = S_NAME_HDR;
                        end
                     end else if (status.name_full) begin
                        cmd.err_wr  = 1'b1;
                        cmd.err_val = ERR_SYMLEN;
                     end else begin
                        cmd.store_char = 1'b1;
                     end
                  end

                  MODE_INDEX: begin
                     if (status.is_digit) begin
                        if (status.digit_ovf) begin
                           cmd.err_wr  = 1'b1;
                           cmd.err_val = ERR_INDEX;
                        end else begin
                           cmd.acc_digit = 1'b1;
                        end
                     end else if (status.is_rbr && !status.digits_zero) begin
                        cmd.mode_wr  = 1'b1;
                        cmd.mode_val = MODE_AFTER;
                        if (!status.index_fits) begin
                           cmd.err_wr  = 1'b1;
                           cmd.err_val = ERR_LONG;
                        end else begin
                           cmd.idx_start = 1'b1;
                           state_in      = S_INDEX;
                        end
                     end else begin
                        cmd.err_wr  = 1'b1;
                        cmd.err_val = ERR_INDEX;
                        if (status.is_nul) begin
                           state_in = S_CLOSE;
                        end
                     end
                  end

                  default: begin
                     if (status.is_lbr) begin
                        cmd.idx_clear = 1'b1;
                     end else if (status.is_dot) begin
                        cmd.mode_wr    = 1'b1;
                        cmd.mode_val   = MODE_NAME;
                        cmd.name_clear = 1'b1;
                     end else if (status.is_nul) begin
                        state_in = S_CLOSE;
                     end else begin
                        cmd.err_wr  = 1'b1;
                        cmd.err_val = ERR_CHAR;
                     end
                  end
               endcase
            end
         end

         S_NAME_HDR: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_HDR;
               state_in = S_NAME_LEN;
            end
         end

         S_NAME_LEN: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_LEN;
               state_in = S_NAME_BODY;
            end
         end

         S_NAME_BODY: begin
            if (status.out_free) begin
               cmd.emit   = 1'b1;
               cmd.sel    = SEL_BODY;
               cmd.rd_adv = 1'b1;
               if (status.name_last) begin
                  if (status.name_odd) begin
                     state_in = S_NAME_PAD;
                  end else begin
                     cmd.name_clear = 1'b1;
                     state_in = close_after_ff ? S_CLOSE : S_IDLE;
                  end
               end
            end
         end

         S_NAME_PAD: begin
            if (status.out_free) begin
               cmd.emit       = 1'b1;
               cmd.sel        = SEL_PAD;
               cmd.name_clear = 1'b1;
               state_in       = close_after_ff ? S_CLOSE : S_IDLE;
            end
         end

         S_INDEX: begin
            if (status.out_free) begin
               cmd.emit    = 1'b1;
               cmd.sel     = SEL_IDX;
               cmd.idx_adv = 1'b1;
               if (status.idx_last) begin
                  state_in = S_IDLE;
               end
            end
         end

         S_CLOSE: begin
            if (status.out_free) begin
               cmd.emit_close = 1'b1;
               cmd.clear_all  = 1'b1;
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/symbolic_tag_path_encoder.sv -----
// Symbolic tag path encoder: turns a NUL-terminated tag name into symbolic path bytes.
// Top level; instantiates stpe_ctrl and stpe_dp, uses stpe_pkg and the assertion macros.
//
// Usage. The req channel carries one tag character per word; a zero character
// ends the path. The rsp channel carries one path byte per word (rsp_tuser high),
// and every terminator yields exactly one closing word (rsp_tuser low, rsp_tlast
// high) holding the error code and the total byte count (zero on an error).
// On a nonzero error code the receiver drops the bytes already taken for that path.
// The controller takes a character in S_IDLE and decodes it in S_DECODE, and takes
// no new character until that one is done; for a delimiter it then sends the segment
// at one word per cycle while rsp_tready allows. A '[', '.' or terminator after a name
// of n bytes sends a header, a length byte, the n name bytes and a pad byte when n is
// odd, and a terminator adds the closing word; an index segment is 2, 4 or 6 bytes.
// While the output is free the name buffer is read at one byte a cycle, the segment rate.
// Reset (synchronous, active high) returns the parser to name mode with no error.
// While the receiver holds rsp_tready low, the output register holds its word and the
// controller waits in its sending state, so req_tready stays low until the last word
// of the segment has been loaded into the output register.
`include "symbolic_tag_path_encoder_defines.svh"

module symbolic_tag_path_encoder #(
   parameter int MAX_NAME_LEN   = 40,
   parameter int MAX_PATH_BYTES = 512
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] char_code
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [stpe_pkg::RSP_DATA_W-1:0] rsp_tdata,   // [7:0] path_byte, [10:8] error_code,
                                                        // [20:11] path_length, [23:21] zero
   output logic                            rsp_tuser,   // [0] byte_valid
   output logic                            rsp_tlast    // last_item
);
   import stpe_pkg::*;

   cmd_type    cmd;
   status_type status;

   stpe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .status     (status),
      .cmd        (cmd)
   );

   stpe_dp #(
      .MAX_NAME_LEN   (MAX_NAME_LEN),
      .MAX_PATH_BYTES (MAX_PATH_BYTES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // The controller only takes a character when it has nothing to send.
   assign req_tready = cmd.take;

   // A word is only loaded into the output register when it is free or being drained.
   `STPE_ASSERT_SAME(a_load_free, clock, reset, cmd.emit || cmd.emit_close, status.out_free, "output word overwritten")
   // Taking a character and sending a segment never happen in the same cycle.
   `STPE_ASSERT_SAME(a_take_idle, clock, reset, req_tready, !cmd.emit && !cmd.emit_close, "input taken while sending")
   // Data words carry no error code and no length, and never close a path.
   `STPE_ASSERT_SAME(a_data_word, clock, reset, rsp_tvalid && rsp_tuser, (rsp_tdata[20:8] == 13'd0) && !rsp_tlast, "data word carries status")
   // Loading a closing word returns the parser to a clean state.
   `STPE_ASSERT_NEXT(a_close_clear, clock, reset, cmd.emit_close, status.emitted_zero && !status.err_set, "state not cleared after close")

endmodule
